### sv/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

  // Default geometry and register reset
  localparam int unsigned ArpcEntries = 16;
  localparam logic [15:0] ArpcTimeoutReset = 16'd300;

  // Operation codes carried in the input tuser
  localparam logic [1:0] OpLookup = 2'd0;
  localparam logic [1:0] OpInsert = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;

  // Microprogram addresses
  typedef enum logic [1:0] {
    StepIdle   = 2'd0,
    StepScan   = 2'd1,
    StepCommit = 2'd2,
    StepResult = 2'd3
  } step_e;

  // Branch conditions: taken -> target, else next address
  typedef enum logic [1:0] {
    CondNext     = 2'd0,
    CondNoBeat   = 2'd1,
    CondScanBusy = 2'd2,
    CondOutBusy  = 2'd3
  } cond_e;

  typedef struct packed {
    logic  accept;
    logic  scan;
    logic  commit;
    logic  load;
    cond_e cond;
    step_e target;
  } ucode_t;

  // Datapath strobes decoded from the current control word
  typedef struct packed {
    logic in_ready;
    logic start;
    logic scan;
    logic commit;
    logic load_out;
  } ctl_t;

  // Branch inputs seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [47:0] mac;
  } res_t;

endpackage
`default_nettype wire

### sv/arpc_ucode.sv
`default_nettype none
module arpc_ucode
  import arpc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  // Four-step ring: the result step falls through back to idle.
  function automatic ucode_t rom(input step_e s);
    ucode_t w;
    w = '0;
    unique case (s)
      StepIdle: begin
        w.accept = 1'b1;
        w.cond   = CondNoBeat;
        w.target = StepIdle;
      end
      StepScan: begin
        w.scan   = 1'b1;
        w.cond   = CondScanBusy;
        w.target = StepScan;
      end
      StepCommit: begin
        w.commit = 1'b1;
        w.cond   = CondNext;
        w.target = StepIdle;
      end
      StepResult: begin
        w.load   = 1'b1;
        w.cond   = CondOutBusy;
        w.target = StepResult;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  step_e  pc_q, pc_d;
  ucode_t uw;
  logic   taken;

  assign uw = rom(pc_q);

  // next step
  always_comb begin
    unique case (uw.cond)
      CondNext:     taken = 1'b0;
      CondNoBeat:   taken = !stat_i.in_valid;
      CondScanBusy: taken = !stat_i.scan_last;
      CondOutBusy:  taken = stat_i.out_busy;
      default:      taken = 1'b0;
    endcase
    pc_d = taken ? uw.target : step_e'(2'(pc_q + 2'd1));
  end

  // control outputs
  always_comb begin
    ctl_o.in_ready = uw.accept;
    ctl_o.start    = uw.accept && stat_i.in_valid;
    ctl_o.scan     = uw.scan;
    ctl_o.commit   = uw.commit;
    ctl_o.load_out = uw.load && !stat_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= StepIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

### sv/arpc_store.sv
`default_nettype none
module arpc_store
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ArpcEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] ip_i,
  input  logic [47:0] mac_i,
  input  logic [15:0] timeout_i,
  output logic        scan_last_o,
  output res_t        res_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // entry storage
  logic [31:0] ip_mem  [ENTRIES];
  logic [47:0] mac_mem [ENTRIES];
  logic [15:0] age_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  // scan pointer and evaluate stage
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] eidx_q;
  logic          ev_vld_q;
  logic          issue;
  logic [IW-1:0] rd_addr;
  logic [31:0]   ip_rd_q;
  logic [47:0]   mac_rd_q;
  logic [15:0]   age_rd_q;

  // scan results
  logic          match_q, free_q;
  logic [IW-1:0] match_idx_q, free_idx_q, old_idx_q, slot;
  logic [15:0]   old_age_q;
  logic [47:0]   mac_hit_q;

  // write port
  logic          we_full, we_age;
  logic [IW-1:0] wr_addr;
  logic [15:0]   wr_age;

  logic          ev_valid, ip_eq;
  logic [16:0]   age_inc;
  logic [15:0]   age_sat;
  logic          age_live;
  logic          do_insert, do_age;

  assign issue   = ctl_i.scan && (cnt_q != CW'(ENTRIES));
  assign rd_addr = cnt_q[IW-1:0];

  assign ev_valid = valid_q[eidx_q];
  assign ip_eq    = (ip_rd_q == ip_i);

  // saturating age step for a tick
  assign age_inc  = {1'b0, age_rd_q} + 17'd1;
  assign age_sat  = (age_inc > {1'b0, timeout_i}) ? timeout_i : age_inc[15:0];
  assign age_live = (age_sat < timeout_i);

  assign slot = match_q ? match_idx_q : (free_q ? free_idx_q : old_idx_q);

  assign do_insert = ctl_i.commit && (op_i == OpInsert);
  assign do_age    = ev_vld_q && (op_i == OpTick) && ev_valid;

  assign scan_last_o = ev_vld_q && (eidx_q == IW'(ENTRIES - 1));

  always_comb begin
    we_full = 1'b0;
    we_age  = 1'b0;
    wr_addr = eidx_q;
    wr_age  = age_sat;
    if (do_insert) begin
      we_full = 1'b1;
      wr_addr = slot;
      wr_age  = '0;
    end else if (do_age) begin
      we_age  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_full) ip_mem[wr_addr] <= ip_i;
    if (issue) ip_rd_q <= ip_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_full) mac_mem[wr_addr] <= mac_i;
    if (issue) mac_rd_q <= mac_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_full || we_age) age_mem[wr_addr] <= wr_age;
    if (issue) age_rd_q <= age_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_insert) begin
      valid_q[slot] <= 1'b1;
    end else if (do_age) begin
      valid_q[eidx_q] <= age_live;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ev_vld_q <= 1'b0;
      eidx_q   <= '0;
    end else begin
      ev_vld_q <= issue;
      eidx_q   <= rd_addr;
      if (ctl_i.start) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // first match, lowest free slot, oldest entry (strictly greater wins)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (ctl_i.start) begin
      match_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (ev_vld_q) begin
      if (ev_valid && ip_eq && !match_q) match_q <= 1'b1;
      if (!ev_valid && !free_q) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_vld_q) begin
      if (ev_valid && ip_eq && !match_q) begin
        match_idx_q <= eidx_q;
        mac_hit_q   <= mac_rd_q;
      end
      if (!ev_valid && !free_q) free_idx_q <= eidx_q;
      if ((eidx_q == '0) || (age_rd_q > old_age_q)) begin
        old_idx_q <= eidx_q;
        old_age_q <= age_rd_q;
      end
    end
  end

  always_comb begin
    res_o.hit     = match_q && ((op_i == OpLookup) || (op_i == OpInsert));
    res_o.evicted = (op_i == OpInsert) && !match_q && !free_q;
    res_o.mac     = ((op_i == OpLookup) && match_q) ? mac_hit_q : '0;
  end

  a_start_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> (cnt_q == '0))
    else $error("scan pointer not rewound on start");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> valid_q[$past(slot)])
    else $error("inserted slot not valid");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_insert && !match_q && !free_q) |-> (&valid_q))
    else $error("eviction while a free slot exists");

  a_tick_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_vld_q && (op_i == OpTick)) |=>
      ($countones(valid_q) <= $past($countones(valid_q))))
    else $error("tick made an entry valid");

endmodule
`default_nettype wire

### sv/arp_cache_table.sv
`default_nettype none
// IPv4-to-MAC cache with ENTRIES slots. Each input beat is one operation,
// selected by s_axis_tuser: lookup, insert/update, or aging tick (code 3 is
// a no-op that still returns a zero result). Every beat yields exactly one
// result beat. Insert refreshes a matching entry, else fills the lowest free
// slot, else evicts the oldest entry (lowest index on ties). Ticks age valid
// entries, saturating at timeout_ticks, and drop those that reach it.
// A small microprogram steps one scan over all slots per operation through
// a single read port, one entry per cycle; each operation runs its scan,
// commit and result steps before the next input beat is taken, as long
// as the result register drains. The next input is taken while a finished
// result still waits in the output register. The store needs no clearing
// pass after reset; valid bits clear at once. Write timeout_ticks only
// while idle.
module arp_cache_table
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ArpcEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // timeout_ticks register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // operation beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [31:0] ip_addr, [79:32] mac_addr
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] mac_out
  output logic [1:0]  m_axis_tuser    // [0] hit, [1] evicted
);

  ctl_t  ctl;
  stat_t stat;
  res_t  res;
  logic  scan_last;

  logic [15:0] timeout_q;
  logic [1:0]  op_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;

  logic        out_vld_q, out_vld_d;
  logic [47:0] out_mac_q;
  logic [1:0]  out_flags_q;

  assign stat.in_valid  = s_axis_tvalid;
  assign stat.scan_last = scan_last;
  assign stat.out_busy  = out_vld_q && !m_axis_tready;

  assign s_axis_tready = ctl.in_ready;

  arpc_ucode u_ucode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  arpc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .op_i        (op_q),
    .ip_i        (ip_q),
    .mac_i       (mac_q),
    .timeout_i   (timeout_q),
    .scan_last_o (scan_last),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ArpcTimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // operation latched for the whole scan
  always_ff @(posedge clk_i) begin
    if (ctl.start) begin
      op_q  <= s_axis_tuser;
      ip_q  <= s_axis_tdata[31:0];
      mac_q <= s_axis_tdata[79:32];
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (ctl.load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.load_out) begin
      out_mac_q   <= res.mac;
      out_flags_q <= {res.evicted, res.hit};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_mac_q;
  assign m_axis_tuser  = out_flags_q;

endmodule
`default_nettype wire

### tb/arp_cache_table_checker.sv
`timescale 1ns / 100ps
module arp_cache_table_checker
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = ArpcEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // [31:0] ip_addr, [79:32] mac_addr
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [47:0] mac_out
  input  logic [1:0]  m_axis_tuser,   // [0] hit, [1] evicted
  output int          mismatches_o,
  output int          replies_owed_o
);

  // shadow copy of the cache
  logic        slot_valid [ENTRIES];
  logic [31:0] slot_ip    [ENTRIES];
  logic [47:0] slot_mac   [ENTRIES];
  logic [15:0] slot_age   [ENTRIES];
  logic [15:0] timeout_ticks;

  res_t replies_due [$];
  int   mismatches;
  int   reply_num;

  // applies one operation to the shadow cache, returns the reply it owes
  function automatic res_t resolve_op(input logic [1:0] kind, input logic [31:0] ip,
                                      input logic [47:0] mac);
    res_t        r;
    int          match;
    int          victim;
    logic [16:0] aged;
    r = '0;
    match = -1;
    victim = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match < 0 && slot_valid[i] && slot_ip[i] == ip) match = i;
    end
    case (kind)
      OpLookup: begin
        if (match >= 0) begin
          r.hit = 1'b1;
          r.mac = slot_mac[match];
        end
      end
      OpInsert: begin
        if (match >= 0) begin
          slot_mac[match] = mac;
          slot_age[match] = '0;
          r.hit = 1'b1;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (victim < 0 && !slot_valid[i]) victim = i;
          end
          if (victim < 0) begin
            // full: oldest goes, lowest index wins ties
            victim = 0;
            for (int i = 1; i < ENTRIES; i++) begin
              if (slot_age[i] > slot_age[victim]) victim = i;
            end
            r.evicted = 1'b1;
          end
          slot_valid[victim] = 1'b1;
          slot_ip[victim] = ip;
          slot_mac[victim] = mac;
          slot_age[victim] = '0;
        end
      end
      OpTick: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) begin
            aged = slot_age[i] + 17'd1;
            if (aged > {1'b0, timeout_ticks}) aged = {1'b0, timeout_ticks};
            slot_age[i] = aged[15:0];
            if (slot_age[i] >= timeout_ticks) slot_valid[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_ip[i] = '0;
        slot_mac[i] = '0;
        slot_age[i] = '0;
      end
      timeout_ticks = ArpcTimeoutReset;
      replies_due.delete();
      mismatches = 0;
      reply_num = 0;
      mismatches_o <= 0;
      replies_owed_o <= 0;
    end else begin
      // result side first: a reply never belongs to an op taken on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit = m_axis_tuser[0];
        got.evicted = m_axis_tuser[1];
        got.mac = m_axis_tdata;
        if (replies_due.size() == 0) begin
          flag($sformatf("reply %0d with none owed: hit %b evicted %b mac %h",
                         reply_num, got.hit, got.evicted, got.mac));
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit || got.evicted !== want.evicted ||
              got.mac !== want.mac) begin
            flag($sformatf("reply %0d (exp/act): hit %b/%b evicted %b/%b mac %h/%h",
                           reply_num, want.hit, got.hit, want.evicted, got.evicted,
                           want.mac, got.mac));
          end
        end
        reply_num++;
      end
      if (cfg_we_i) timeout_ticks = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        replies_due.push_back(resolve_op(s_axis_tuser, s_axis_tdata[31:0],
                                         s_axis_tdata[79:32]));
      end
      mismatches_o <= mismatches;
      replies_owed_o <= replies_due.size();
    end
  end

endmodule

### tb/arp_cache_table_tb.sv
`timescale 1ns / 100ps
module arp_cache_table_tb;
  import arpc_pkg::*;

  localparam int unsigned ENTRIES = ArpcEntries;
  // kind 3 has no name in the package; the block treats it as a no-op
  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned StallMax = 18;
  // no beat for this many cycles means the block is stuck
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned OpsPerPhase = 195;
  // more addresses than slots, so a busy phase keeps the table full
  localparam int unsigned PoolSize = 24;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // [31:0] ip_addr, [79:32] mac_addr
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [47:0] mac_out
  logic [1:0]  m_axis_tuser;        // [0] hit, [1] evicted

  int          mismatches;
  int          replies_owed;
  int unsigned quiet_cycles = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_beats = 0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;
  logic [31:0] ip_pool [PoolSize];

  arp_cache_table #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // watches both streams and the register port, keeps its own cache copy
  arp_cache_table_checker #(
    .ENTRIES(ENTRIES)
  ) u_reply_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches_o  (mismatches),
    .replies_owed_o(replies_owed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: after each beat, hold tready low for a random stall.
  // Every 64 beats a new mode is drawn; calm mode means no stalls at all.
  always @(posedge clk_i or negedge rst_ni) begin : rx_side
    int unsigned pause;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_axis_tready && m_axis_tvalid) begin
      rx_beats = rx_beats + 1;
      if (rx_beats % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      pause = rx_calm ? 0 : $urandom_range(0, StallMax);
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait <= pause - 1;
      end
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) m_axis_tready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // Watchdog: counts cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Waits until every op sent so far has had its reply. The count is
  // registered in the checker, so it trails the queue; that only adds margin.
  task automatic wait_drained();
    do @(posedge clk_i); while (replies_owed != 0);
  endtask

  // Sends one op beat. Called at the edge that took the previous beat, so
  // tvalid is touched at most once per time step.
  task automatic send_op(input logic [1:0] kind, input logic [31:0] ip,
                         input logic [47:0] mac, input bit drain);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, StallMax);
    if (gap != 0 || drain) begin
      s_axis_tvalid <= 1'b0;
      if (drain) wait_drained();
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {mac, ip};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // timeout_ticks may only change with the block idle: drain, let the
  // sequencer settle back to idle, then write
  task automatic set_timeout(input logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (ENTRIES + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [47:0] rand_mac();
    logic [47:0] m;
    m[47:32] = 16'($urandom);
    m[31:0] = $urandom;
    case ($urandom_range(0, 19))
      0: m = '0;
      1: m = '1;
      default: ;
    endcase
    return m;
  endfunction

  // Mostly pool addresses so lookups hit and inserts refresh or evict;
  // a few extremes and fully random ones for misses.
  function automatic logic [31:0] pick_ip();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 82) return ip_pool[$urandom_range(0, PoolSize - 1)];
    if (roll < 86) return 32'h0;
    if (roll < 90) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One phase: new timeout, roughly half the pool renewed, then a random op mix.
  task automatic run_phase(input logic [15:0] timeout);
    int unsigned roll;
    logic [1:0]  kind;
    set_timeout(timeout);
    for (int i = 0; i < PoolSize; i++) begin
      if ($urandom_range(0, 1) == 0) ip_pool[i] = $urandom;
    end
    for (int n = 0; n < OpsPerPhase; n++) begin
      if (n % 60 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 40) kind = OpLookup;
      else if (roll < 75) kind = OpInsert;
      else if (roll < 94) kind = OpTick;
      else kind = OpNone;
      // now and then hold off until the block has answered everything
      send_op(kind, pick_ip(), rand_mac(), $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin : stimulus
    for (int i = 0; i < PoolSize; i++) ip_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, default timeout ---
    send_op(OpLookup, 32'h0, 48'h0, 1'b0);                  // miss on empty table
    send_op(OpInsert, 32'h0, 48'h0, 1'b0);                  // lowest free slot
    send_op(OpInsert, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_op(OpLookup, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b0);     // hit, mac all zero
    send_op(OpLookup, 32'hFFFF_FFFF, 48'h0, 1'b0);          // hit, mac all ones
    send_op(OpInsert, 32'h0, 48'hA5A5_5A5A_C3C3, 1'b0);     // refresh
    send_op(OpNone, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_op(OpTick, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    // fill the rest, with ticks in between so ages differ
    for (int i = 1; i <= ENTRIES - 2; i++) begin
      send_op(OpInsert, 32'hC0A8_0000 + i, rand_mac(), 1'b0);
      if (i % 5 == 0) send_op(OpTick, $urandom, rand_mac(), 1'b0);
    end
    // full table: slots 0 and 1 tie on the greatest age, slot 0 goes
    send_op(OpInsert, 32'h0A0A_0A0A, rand_mac(), 1'b0);
    send_op(OpLookup, 32'h0, 48'h0, 1'b0);

    // --- random phases; state carries across them ---
    run_phase(16'd1);       // every tick wipes the table
    run_phase(16'd65535);   // nothing expires, ages build up
    run_phase(16'd2);       // lowered: old entries saturate and go
    run_phase(16'd0);       // out of range, any tick clears all
    run_phase(16'd6);
    run_phase(ArpcTimeoutReset);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    // give a stray extra beat time to show up
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
